// File: src/bcst_pkg.sv
// Shared types, register indexes and constants of the battery charge state tracker.
package bcst_pkg;

    localparam int LEVEL_BITS_DEF = 10;
    localparam int AVG_LOG2_DEF   = 2;

    // Configuration register file.
    localparam int CFG_COUNT = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_RIPPLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_RIPPLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_PEAK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECHARGE_PEAK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TROUGH = 3'd4;

    localparam int RST_CHARGE_RIPPLE = 15;
    localparam int RST_QUIET_RIPPLE  = 7;
    localparam int RST_FULL_PEAK     = 1020;
    localparam int RST_RECHARGE_PEAK = 1000;
    localparam int RST_NORMAL_TROUGH = 1000;

    // Gauge mapping of the trough reading.
    localparam int GAUGE_W          = 11;
    localparam int GAUGE_LOW        = 'h320;
    localparam int GAUGE_HIGH       = 'h380;
    localparam int GAUGE_STEP_LOG2  = 3;
    localparam int GAUGE_SEG_W      = 4;
    localparam logic [GAUGE_SEG_W-1:0] GAUGE_FULL = 4'd12;
    localparam logic [GAUGE_SEG_W-1:0] GAUGE_NONE = 4'd0;

    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_CHARGING = 2'd1,
        MODE_DONE     = 2'd2
    } t_mode;

endpackage

// File: src/bcst_cfg_regs.sv
// Threshold register file written through the configuration channel.
module bcst_cfg_regs #(
    parameter int LEVEL_BITS = bcst_pkg::LEVEL_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_valid,
    output logic                                              o_cfg_ready,
    input  logic [bcst_pkg::CFG_IDX_W-1:0]                    i_cfg_index,
    input  logic [LEVEL_BITS-1:0]                             i_cfg_data,
    output logic [bcst_pkg::CFG_COUNT-1:0][LEVEL_BITS-1:0]    o_cfg
);
    import bcst_pkg::*;

    logic [CFG_COUNT-1:0][LEVEL_BITS-1:0] r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_CHARGE_RIPPLE] <= LEVEL_BITS'(RST_CHARGE_RIPPLE);
            r_cfg[CFG_QUIET_RIPPLE]  <= LEVEL_BITS'(RST_QUIET_RIPPLE);
            r_cfg[CFG_FULL_PEAK]     <= LEVEL_BITS'(RST_FULL_PEAK);
            r_cfg[CFG_RECHARGE_PEAK] <= LEVEL_BITS'(RST_RECHARGE_PEAK);
            r_cfg[CFG_NORMAL_TROUGH] <= LEVEL_BITS'(RST_NORMAL_TROUGH);
        end else if (i_cfg_valid) begin
            // Writes to indexes beyond the register file are dropped.
            case (i_cfg_index)
                CFG_CHARGE_RIPPLE: r_cfg[CFG_CHARGE_RIPPLE] <= i_cfg_data;
                CFG_QUIET_RIPPLE:  r_cfg[CFG_QUIET_RIPPLE]  <= i_cfg_data;
                CFG_FULL_PEAK:     r_cfg[CFG_FULL_PEAK]     <= i_cfg_data;
                CFG_RECHARGE_PEAK: r_cfg[CFG_RECHARGE_PEAK] <= i_cfg_data;
                CFG_NORMAL_TROUGH: r_cfg[CFG_NORMAL_TROUGH] <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: src/bcst_ripple_avg.sv
// Ripple ring with a running sum; gives the average including the current beat.
module bcst_ripple_avg #(
    parameter int LEVEL_BITS = bcst_pkg::LEVEL_BITS_DEF,
    parameter int AVG_LOG2   = bcst_pkg::AVG_LOG2_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [LEVEL_BITS-1:0] i_peak,
    input  logic [LEVEL_BITS-1:0] i_trough,
    output logic [LEVEL_BITS-1:0] o_avg
);
    import bcst_pkg::*;

    localparam int DEPTH = 1 << AVG_LOG2;
    localparam int SUM_W = LEVEL_BITS + AVG_LOG2;

    logic [DEPTH-1:0][LEVEL_BITS-1:0] r_ring;
    logic [AVG_LOG2-1:0]              r_slot;
    logic [SUM_W-1:0]                 r_sum;
    logic [SUM_W-1:0]                 n_sum;
    logic [LEVEL_BITS-1:0]            w_ripple;

    // A trough above the peak counts as no ripple at all.
    assign w_ripple = (i_peak > i_trough) ? (i_peak - i_trough) : '0;

    // The sum tracks the ring: the entry being overwritten leaves, the new ripple joins.
    assign n_sum = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(w_ripple);
    assign o_avg = n_sum[SUM_W-1:AVG_LOG2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
            r_slot <= '0;
            r_sum  <= '0;
        end else if (i_step) begin
            r_ring[r_slot] <= w_ripple;
            r_slot         <= r_slot + 1'b1;
            r_sum          <= n_sum;
        end
    end

    a_slot_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_slot == $past(r_slot) + 1'b1)
        else $error("ring slot did not advance on a beat");

    a_ring_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_ring[$past(r_slot)] == $past(w_ripple))
        else $error("ring entry does not hold the stored ripple");

    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_sum) && $stable(r_slot))
        else $error("running sum changed without a beat");

endmodule

// File: src/bcst_mode_fsm.sv
// Charge mode state machine with the quiet-ripple override to normal.
module bcst_mode_fsm #(
    parameter int LEVEL_BITS = bcst_pkg::LEVEL_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_step,
    input  logic [LEVEL_BITS-1:0]                          i_avg,
    input  logic [LEVEL_BITS-1:0]                          i_peak,
    input  logic [LEVEL_BITS-1:0]                          i_trough,
    input  logic [bcst_pkg::CFG_COUNT-1:0][LEVEL_BITS-1:0] i_cfg,
    output bcst_pkg::t_mode                                o_mode
);
    import bcst_pkg::*;

    t_mode r_mode;
    t_mode n_mode;
    logic  w_override;

    assign w_override = (i_avg < i_cfg[CFG_QUIET_RIPPLE])
                     && (i_trough < i_cfg[CFG_NORMAL_TROUGH]);

    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_NORMAL: begin
                if (i_avg > i_cfg[CFG_CHARGE_RIPPLE]) n_mode = MODE_CHARGING;
            end
            MODE_CHARGING: begin
                if (i_peak >= i_cfg[CFG_FULL_PEAK]) n_mode = MODE_DONE;
            end
            MODE_DONE: begin
                if (i_peak < i_cfg[CFG_RECHARGE_PEAK]) n_mode = MODE_CHARGING;
            end
            default: ;
        endcase
        // The override is applied after the transition and wins over it.
        if (w_override) n_mode = MODE_NORMAL;
    end

    // The result carries the mode after this beat.
    always_comb begin
        o_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_step) begin
            r_mode <= n_mode;
        end
    end

    a_override_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_override |=> r_mode == MODE_NORMAL)
        else $error("override to normal not taken");

    a_no_skip_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_mode == MODE_NORMAL |=> r_mode != MODE_DONE)
        else $error("normal moved straight to charge done");

    a_mode_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode))
        else $error("mode changed without a beat");

endmodule

// File: src/battery_charge_state_tracker.sv
// Battery charge state tracker: input register, single-pass update, result register.
// An accepted beat passes the input register and then the result register to the master side.
// Throughput: one beat per cycle without master stalls; ring, sum and mode update in one pass.
// An empty input register takes a beat while a result waits; with both registers full the
// input stalls, and it resumes in the same cycle that the master side takes the result.
// Reset (synchronous, active low) clears the ring, running sum, slot and mode to normal,
// loads the threshold registers with their defaults, and empties both registers.
module battery_charge_state_tracker #(
    parameter int LEVEL_BITS = bcst_pkg::LEVEL_BITS_DEF,
    parameter int AVG_LOG2   = bcst_pkg::AVG_LOG2_DEF,
    localparam int IN_W  = ((2 * LEVEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((bcst_pkg::MODE_W + LEVEL_BITS + bcst_pkg::GAUGE_SEG_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: peak_level, trough_level, zero padding.
    input  logic [IN_W-1:0]                s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: charge_mode, average_ripple, gauge_segments, zero padding.
    output logic [OUT_W-1:0]               m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bcst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_BITS-1:0]          i_cfg_data
);
    import bcst_pkg::*;

    localparam int CMP_W = (LEVEL_BITS > GAUGE_W) ? LEVEL_BITS : GAUGE_W;

    logic                                 r_in_valid;
    logic [LEVEL_BITS-1:0]                r_in_peak;
    logic [LEVEL_BITS-1:0]                r_in_trough;
    logic                                 r_out_valid;
    t_mode                                r_out_mode;
    logic [LEVEL_BITS-1:0]                r_out_avg;
    logic [GAUGE_SEG_W-1:0]               r_out_gauge;

    logic                                 w_step;
    logic [CFG_COUNT-1:0][LEVEL_BITS-1:0] w_cfg;
    logic [LEVEL_BITS-1:0]                w_avg;
    t_mode                                w_mode;
    logic [CMP_W-1:0]                     w_trough_x;
    logic [CMP_W-1:0]                     w_gauge_off;
    logic [GAUGE_SEG_W-1:0]               w_gauge;

    // An item moves into the result register when that register is free or being emptied.
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_gauge, r_out_avg, r_out_mode});

    bcst_cfg_regs #(.LEVEL_BITS(LEVEL_BITS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bcst_ripple_avg #(.LEVEL_BITS(LEVEL_BITS), .AVG_LOG2(AVG_LOG2)) u_ripple (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_peak   (r_in_peak),
        .i_trough (r_in_trough),
        .o_avg    (w_avg)
    );

    bcst_mode_fsm #(.LEVEL_BITS(LEVEL_BITS)) u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_avg    (w_avg),
        .i_peak   (r_in_peak),
        .i_trough (r_in_trough),
        .i_cfg    (w_cfg),
        .o_mode   (w_mode)
    );

    // Inside the gauge window the offset is below 128, so its upper bits give the bar count.
    assign w_trough_x  = CMP_W'(r_in_trough);
    assign w_gauge_off = w_trough_x - CMP_W'(GAUGE_LOW);

    always_comb begin
        if (w_trough_x < CMP_W'(GAUGE_LOW)) begin
            w_gauge = GAUGE_NONE;
        end else if (w_trough_x > CMP_W'(GAUGE_HIGH)) begin
            w_gauge = GAUGE_FULL;
        end else begin
            w_gauge = w_gauge_off[GAUGE_STEP_LOG2 +: GAUGE_SEG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_peak   <= s_axis_tdata[LEVEL_BITS-1:0];
            r_in_trough <= s_axis_tdata[2*LEVEL_BITS-1:LEVEL_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_mode  <= w_mode;
            r_out_avg   <= w_avg;
            r_out_gauge <= w_gauge;
        end
    end

    a_step_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("result register empty after a beat moved into it");

    a_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_in_peak) && $stable(r_in_trough))
        else $error("held input beat lost while the result side stalled");

    a_gauge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_gauge <= GAUGE_FULL)
        else $error("gauge above full scale");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the battery charge state tracker, with its own behavioural predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bcst_pkg::*;

    localparam int LVL        = LEVEL_BITS_DEF;
    localparam int RING_DEPTH = 1 << AVG_LOG2_DEF;
    localparam int IN_W       = ((2 * LVL + 7) / 8) * 8;
    localparam int OUT_W      = ((MODE_W + LVL + GAUGE_SEG_W + 7) / 8) * 8;
    localparam int AVG_LSB    = MODE_W;
    localparam int BARS_LSB   = MODE_W + LVL;
    localparam logic [LVL-1:0] LVL_MAX = '1;

    localparam int PROBE_COUNT    = 22;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_WINDOWS  = 240;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        t_mode            mode;
        logic [LVL-1:0]   ripple_avg;
        logic [GAUGE_SEG_W-1:0] bars;
    } t_reading;

    typedef struct {
        logic [LVL-1:0] peak;
        logic [LVL-1:0] trough;
        bit             given;
        t_reading       want;
    } t_probe;

    typedef struct {
        logic [LVL-1:0] charge_ripple;
        logic [LVL-1:0] quiet_ripple;
        logic [LVL-1:0] full_peak;
        logic [LVL-1:0] recharge_peak;
        logic [LVL-1:0] normal_trough;
    } t_limits;

    typedef enum int {
        NOISY_WINDOW,
        QUIET_WINDOW,
        RIPPLY_WINDOW,
        TOPPED_WINDOW,
        SAGGING_WINDOW
    } t_window_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // Fields from bit 0: peak_level, trough_level, zero padding.
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // Fields from bit 0: charge_mode, average_ripple, gauge_segments.
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LVL-1:0]       i_cfg_data;

    battery_charge_state_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Tracker shadow state.
    logic [LVL-1:0]          ripple_ring [RING_DEPTH];
    logic [AVG_LOG2_DEF-1:0] ring_slot;
    t_mode                   tracked_mode;
    t_limits                 limits;

    t_reading    pending_readings [$];
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          hold_off_req = 1'b0;
    t_reading    head;

    // Edges of every field, each mode transition and the gauge boundaries.
    t_probe probes [PROBE_COUNT] = '{
        '{10'd0,    10'd0,    1'b1, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd1023, 10'd0,    1'b1, '{MODE_CHARGING, 10'd255, GAUGE_NONE}},
        '{10'd1023, 10'd1023, 1'b1, '{MODE_DONE,     10'd255, GAUGE_FULL}},
        '{10'd0,    10'd1023, 1'b1, '{MODE_CHARGING, 10'd255, GAUGE_FULL}},
        '{10'h320,  10'h320,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd1023, 10'h31f,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd900,  10'h327,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd900,  10'h328,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd900,  10'h37f,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd900,  10'h380,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd900,  10'h381,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd1023, 10'd1020, 1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd1000, 10'd999,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd999,  10'd999,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd500,  10'd500,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd500,  10'd500,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd500,  10'd500,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd500,  10'd500,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'h2aa,  10'h155,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'h155,  10'h2aa,  1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd1023, 10'd1,    1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}},
        '{10'd1,    10'd0,    1'b0, '{MODE_NORMAL,   10'd0,   GAUGE_NONE}}
    };

    function automatic void reset_tracker();
        foreach (ripple_ring[k]) ripple_ring[k] = '0;
        ring_slot                = '0;
        tracked_mode             = MODE_NORMAL;
        limits.charge_ripple     = LVL'(RST_CHARGE_RIPPLE);
        limits.quiet_ripple      = LVL'(RST_QUIET_RIPPLE);
        limits.full_peak         = LVL'(RST_FULL_PEAK);
        limits.recharge_peak     = LVL'(RST_RECHARGE_PEAK);
        limits.normal_trough     = LVL'(RST_NORMAL_TROUGH);
    endfunction

    function automatic t_reading track_window(input logic [LVL-1:0] peak,
                                              input logic [LVL-1:0] trough);
        logic [LVL+AVG_LOG2_DEF-1:0] ring_sum;
        t_reading r;
        ring_sum = '0;
        ripple_ring[ring_slot] = (peak > trough) ? peak - trough : '0;
        ring_slot = ring_slot + 1'b1;
        foreach (ripple_ring[k]) ring_sum = ring_sum + ripple_ring[k];
        r.ripple_avg = LVL'(ring_sum >> AVG_LOG2_DEF);
        case (tracked_mode)
            MODE_NORMAL: begin
                if (r.ripple_avg > limits.charge_ripple) tracked_mode = MODE_CHARGING;
            end
            MODE_CHARGING: begin
                if (peak >= limits.full_peak) tracked_mode = MODE_DONE;
            end
            MODE_DONE: begin
                if (peak < limits.recharge_peak) tracked_mode = MODE_CHARGING;
            end
            default: ;
        endcase
        // The quiet override is applied after the transition, so it wins.
        if (r.ripple_avg < limits.quiet_ripple && trough < limits.normal_trough)
            tracked_mode = MODE_NORMAL;
        r.mode = tracked_mode;
        if (int'(trough) < GAUGE_LOW)
            r.bars = GAUGE_NONE;
        else if (int'(trough) > GAUGE_HIGH)
            r.bars = GAUGE_FULL;
        else
            r.bars = GAUGE_SEG_W'((int'(trough) - GAUGE_LOW) >> GAUGE_STEP_LOG2);
        return r;
    endfunction

    // Offers one window; the valid stays high between beats unless a gap is drawn.
    task automatic send_window(input logic [LVL-1:0] peak, input logic [LVL-1:0] trough,
                               input bit given, input t_reading want);
        t_reading got;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tdata  <= IN_W'({trough, peak});
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = track_window(peak, trough);
        pending_readings.push_back(given ? want : got);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CHARGE_RIPPLE: limits.charge_ripple = val;
            CFG_QUIET_RIPPLE:  limits.quiet_ripple  = val;
            CFG_FULL_PEAK:     limits.full_peak     = val;
            CFG_RECHARGE_PEAK: limits.recharge_peak = val;
            CFG_NORMAL_TROUGH: limits.normal_trough = val;
            default: ;
        endcase
    endtask

    task automatic apply_limits(input t_limits want);
        // An index past the register file must leave every threshold alone.
        write_reg(CFG_IDX_W'($urandom_range(CFG_COUNT, (1 << CFG_IDX_W) - 1)),
                  LVL'($urandom_range(0, 1023)));
        write_reg(CFG_CHARGE_RIPPLE, want.charge_ripple);
        write_reg(CFG_QUIET_RIPPLE,  want.quiet_ripple);
        write_reg(CFG_FULL_PEAK,     want.full_peak);
        write_reg(CFG_RECHARGE_PEAK, want.recharge_peak);
        write_reg(CFG_NORMAL_TROUGH, want.normal_trough);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_limits pick_limits(input bit plausible);
        t_limits l;
        if (plausible) begin
            l.charge_ripple = LVL'($urandom_range(0, 60));
            l.quiet_ripple  = LVL'($urandom_range(0, 20));
            l.full_peak     = LVL'($urandom_range(980, 1023));
            l.recharge_peak = LVL'($urandom_range(900, 1023));
            l.normal_trough = LVL'($urandom_range(700, 1023));
        end else begin
            l.charge_ripple = LVL'($urandom_range(0, 1023));
            l.quiet_ripple  = LVL'($urandom_range(0, 1023));
            l.full_peak     = LVL'($urandom_range(0, 1023));
            l.recharge_peak = LVL'($urandom_range(0, 1023));
            l.normal_trough = LVL'($urandom_range(0, 1023));
        end
        return l;
    endfunction

    function automatic void shape_window(input t_window_kind kind,
                                         output logic [LVL-1:0] peak,
                                         output logic [LVL-1:0] trough);
        int p;
        int t;
        case (kind)
            QUIET_WINDOW: begin
                t = $urandom_range(0, 1023);
                p = t + $urandom_range(0, 6);
            end
            RIPPLY_WINDOW: begin
                t = $urandom_range(0, 1000);
                p = t + $urandom_range(8, 400);
            end
            TOPPED_WINDOW: begin
                p = $urandom_range(1012, 1023);
                t = p - $urandom_range(0, 8);
            end
            SAGGING_WINDOW: begin
                p = $urandom_range(850, 1010);
                t = p - $urandom_range(0, 6);
            end
            default: begin
                p = $urandom_range(0, 1023);
                t = $urandom_range(0, 1023);
            end
        endcase
        peak   = (p > 1023) ? LVL_MAX : LVL'(p);
        trough = LVL'(t);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result beat: data %h", m_axis_tdata);
            end else begin
                head = pending_readings.pop_front();
                if (m_axis_tdata[MODE_W-1:0] !== head.mode
                        || m_axis_tdata[AVG_LSB +: LVL] !== head.ripple_avg
                        || m_axis_tdata[BARS_LSB +: GAUGE_SEG_W] !== head.bars) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch: mode %0d/%0d avg %0d/%0d bars %0d/%0d (exp/act)",
                                 head.mode, m_axis_tdata[MODE_W-1:0],
                                 head.ripple_avg, m_axis_tdata[AVG_LSB +: LVL],
                                 head.bars, m_axis_tdata[BARS_LSB +: GAUGE_SEG_W]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        t_window_kind   kind;
        int             episode_left;
        logic [LVL-1:0] peak;
        logic [LVL-1:0] trough;
        t_limits        setting;
        kind         = NOISY_WINDOW;
        episode_left = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_CHARGE_RIPPLE;
        i_cfg_data    <= '0;
        reset_tracker();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k])
            send_window(probes[k].peak, probes[k].trough, probes[k].given, probes[k].want);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: setting = limits;
                1: setting = '{'0, '0, '0, '0, '0};
                2: setting = '{LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX};
                4: setting = pick_limits(1'b0);
                6: setting = '{'0, LVL_MAX, LVL_MAX, '0, LVL_MAX};
                default: setting = pick_limits(1'b1);
            endcase
            // The reset defaults are run first without any register write.
            if (phase != 0) apply_limits(setting);
            for (int n = 0; n < PHASE_WINDOWS; n++) begin
                if (phase == PHASE_COUNT - 1) begin
                    src_idle_en  = 1'b0;
                    sink_idle_en = 1'b0;
                end else if (n % 32 == 0) begin
                    src_idle_en  = $urandom_range(0, 3) != 0;
                    sink_idle_en = $urandom_range(0, 3) != 0;
                end
                // Hold the result side off while windows keep coming, to fill the block.
                if ((phase == 2 || phase == 5) && n == 60) hold_off_req = 1'b1;
                if (episode_left == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1: kind = NOISY_WINDOW;
                        2, 3: kind = QUIET_WINDOW;
                        4, 5: kind = RIPPLY_WINDOW;
                        6, 7: kind = TOPPED_WINDOW;
                        default: kind = SAGGING_WINDOW;
                    endcase
                    episode_left = $urandom_range(4, 24);
                end
                episode_left--;
                shape_window(kind, peak, trough);
                send_window(peak, trough, 1'b0, head);
            end
            // Every phase ends with the sender paused until all results are back.
            drain_results();
        end

        if (error_count == 0 && pending_readings.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
